// File: sv/normalized_autocorrelation_top_defines.svh
// assertion macros for the normalized autocorrelation block
`ifndef NORMALIZED_AUTOCORRELATION_TOP_DEFINES_SVH
`define NORMALIZED_AUTOCORRELATION_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define NAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define NAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/nac_pkg.sv
// shared constants and types of the normalized autocorrelation block
`timescale 1ns / 1ps
`default_nettype none

package nac_pkg;

    localparam int MAX_SEG_LEN = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_SEG_LEN + 1);
    localparam int LAG_W       = 6;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = 38;
    localparam int Q_W         = 16;
    localparam int DIV_STEPS   = Q_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // beat layouts
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // saturation limits of the q1.15 result
    localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7FFF;
    localparam logic [Q_W-1:0] Q_NEG_MAG = 16'h8000;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// File: sv/normalized_autocorrelation_top.sv
// a segment of N samples is taken one beat per cycle while idle, then lag t runs (N - t)
// products through the shared multiply-accumulate loop, followed by divider setup, the
// bit-serial divider and an output beat that is held until the output ready takes it.
// the one multiplier serves every lag in turn. no input beat is taken while a segment
// is at work.
// reset is synchronous, active low, clears control state; the sample memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "normalized_autocorrelation_top_defines.svh"

module normalized_autocorrelation_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [15:0] sample
    input  wire  [nac_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // segment_end
    input  wire                            i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  wire                            i_m_axis_tready,
    // [5:0] lag, [21:6] value, [23:22] zero
    output logic [nac_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // last_lag
    output logic                           o_m_axis_tlast
);
    import nac_pkg::*;

    t_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] r_mem [STORE_DEPTH];

    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [CNT_W-1:0]           r_len, n_len;
    logic [LAG_W-1:0]           r_t, n_t;
    logic [CNT_W-1:0]           r_n, n_n;
    logic                       r_v1, r_v2;
    logic signed [SAMPLE_W-1:0] r_rd_a, r_rd_b;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic [ACC_W-1:0]           r_energy, n_energy;
    logic [ACC_W:0]             r_rem, n_rem;
    logic                       r_neg, n_neg;
    logic [Q_W-1:0]             r_q, n_q;
    logic [STEP_W-1:0]          r_step, n_step;
    logic                       r_out_valid, n_out_valid;
    logic [LAG_W-1:0]           r_out_lag, n_out_lag;
    logic [Q_W-1:0]             r_out_value, n_out_value;
    logic                       r_out_last, n_out_last;

    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_close;
    logic                 w_issue;
    logic [CNT_W-1:0]     w_diff;
    logic [ADDR_W-1:0]    w_addr_a, w_addr_b;
    logic [ACC_W-1:0]     w_mag;
    logic                 w_ge;
    logic [ACC_W:0]       w_rem_sub;
    logic [Q_W-1:0]       w_q;
    logic [Q_W-1:0]       w_value;
    logic                 w_last;

    // handshakes
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = r_out_valid && i_m_axis_tready;
    assign w_close         = i_s_axis_tlast || (r_fill + 1'b1 == CNT_W'(MAX_SEG_LEN));

    // lag product addresses: x[n] and x[n-t]
    assign w_issue  = (r_state == S_MAC) && (r_n < r_len);
    assign w_diff   = r_n - {1'b0, r_t};
    assign w_addr_a = r_n[ADDR_W-1:0];
    assign w_addr_b = w_diff[ADDR_W-1:0];

    // restoring divide step
    assign w_mag     = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_ge      = r_rem >= {1'b0, r_energy};
    assign w_rem_sub = w_ge ? (r_rem - {1'b0, r_energy}) : r_rem;
    assign w_q       = {r_q[Q_W-2:0], w_ge};
    assign w_last    = ({1'b0, r_t} + 1'b1) == r_len;

    // saturate and apply sign; zero energy gives zero
    always_comb begin
        if (r_energy == '0) begin
            w_value = '0;
        end else if (r_neg) begin
            w_value = (w_q > Q_NEG_MAG) ? Q_NEG_MAG : Q_W'(-w_q);
        end else begin
            w_value = (w_q > Q_POS_MAX) ? Q_POS_MAX : w_q;
        end
    end

    // sample memory with registered reads
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_s_axis_tdata[SAMPLE_W-1:0];
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
        r_prod <= r_rd_a * r_rd_b;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_len       = r_len;
        n_t         = r_t;
        n_n         = r_n;
        n_acc       = r_acc;
        n_energy    = r_energy;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_q         = r_q;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_lag   = r_out_lag;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_close) begin
                        n_fill  = '0;
                        n_len   = r_fill + 1'b1;
                        n_t     = '0;
                        n_n     = '0;
                        n_acc   = '0;
                        n_state = S_MAC;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            S_MAC: begin
                if (w_issue) begin
                    n_n = r_n + 1'b1;
                end
                if (r_v2) begin
                    n_acc = r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                if (!w_issue && !r_v1 && !r_v2) begin
                    if (r_t == '0) begin
                        n_energy = ACC_W'(r_acc);
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_rem   = {1'b0, w_mag};
                n_neg   = r_acc[ACC_W-1];
                n_q     = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = {w_rem_sub[ACC_W-1:0], 1'b0};
                n_q    = w_q;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_out_valid = 1'b1;
                    n_out_lag   = r_t;
                    n_out_value = w_value;
                    n_out_last  = w_last;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_t     = r_t + 1'b1;
                        n_n     = {1'b0, r_t} + 1'b1;
                        n_acc   = '0;
                        n_state = S_MAC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_energy    <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_v1        <= w_issue;
            r_v2        <= r_v1;
            r_out_valid <= n_out_valid;
            r_energy    <= n_energy;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_t         <= n_t;
        r_n         <= n_n;
        r_acc       <= n_acc;
        r_rem       <= n_rem;
        r_neg       <= n_neg;
        r_q         <= n_q;
        r_step      <= n_step;
        r_out_lag   <= n_out_lag;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    // output beat
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-Q_W-LAG_W){1'b0}}, r_out_value, r_out_lag};
    assign o_m_axis_tlast  = r_out_last;

    // checks
    `NAC_ASSERT_NOW(a_no_overlap, o_s_axis_tready, !o_m_axis_tvalid,
        "input taken while a result is pending")
    `NAC_ASSERT_NOW(a_lag0_unity, r_out_valid && (r_out_lag == '0) && (r_energy != '0),
        r_out_value == Q_POS_MAX, "lag zero is not saturated unity")
    `NAC_ASSERT_NEXT(a_close_starts, w_in_acc && w_close, r_state == S_MAC,
        "closing sample did not start the lag loop")
    `NAC_ASSERT_NOW(a_last_flag, r_out_valid,
        r_out_last == (({1'b0, r_out_lag} + 1'b1) == r_len), "last lag flag mismatch")

endmodule

`default_nettype wire
